[rtl/scra_pkg.sv]
// Shared types and codes for the size class record allocator.
package scra_pkg;

  localparam logic [2:0] OP_ALLOC  = 3'd0;
  localparam logic [2:0] OP_APPEND = 3'd1;
  localparam logic [2:0] OP_READ   = 3'd2;
  localparam logic [2:0] OP_ERASE  = 3'd3;
  localparam logic [2:0] OP_CLEAR  = 3'd4;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_BAD_ID     = 3'd1;
  localparam logic [2:0] ST_SIZE       = 3'd2;
  localparam logic [2:0] ST_RECS_FULL  = 3'd3;
  localparam logic [2:0] ST_DATA_FULL  = 3'd4;
  localparam logic [2:0] ST_CLASS_FULL = 3'd5;

  typedef enum logic [1:0] {
    RA_ID   = 2'd0,
    RA_HEAD = 2'd1,
    RA_CUR  = 2'd2
  } ra_sel_t;

  typedef struct packed {
    logic       load_in;
    logic       lookup;
    logic       key_ram;
    ra_sel_t    ra_sel;
    logic       set_st;
    logic [2:0] st_code;
    logic       do_fresh;
    logic       do_reuse;
    logic       do_link;
    logic       do_read;
    logic       do_clear;
    logic       walk_init;
    logic       walk_cmp;
    logic       walk_upd;
    logic       load_out;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       id_ok;
    logic       prev_ok;
    logic       hit;
    logic       head_ok;
    logic       class_full;
    logic       recs_full;
    logic       data_full;
    logic       size_match;
    logic       follow_ok;
    logic       step_last;
  } stat_t;

endpackage

[rtl/scra_ram.sv]
// Generic single write port RAM with registered read.
module scra_ram #(
  parameter int W = 8,
  parameter int D = 2,
  localparam int AW = (D > 1) ? $clog2(D) : 1
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [W-1:0]  wdata,
  input  logic [AW-1:0] raddr,
  output logic [W-1:0]  rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/scra_dp.sv]
// Datapath: record tables, size classes, counters and result words.
module scra_dp import scra_pkg::*; #(
  parameter int MAX_RECORDS  = 256,
  parameter int SIZE_CLASSES = 16,
  parameter int DATA_BYTES   = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [2:0]  in_operation,
  input  logic [15:0] in_record_size,
  input  logic [7:0]  in_record_id,
  input  logic [7:0]  in_prev_id,
  output logic [2:0]  out_status,
  output logic [7:0]  out_result_id,
  output logic [15:0] out_data_offset,
  output logic [8:0]  out_next_id
);

  localparam int RW   = $clog2(MAX_RECORDS);
  localparam int RUW  = $clog2(MAX_RECORDS + 1);
  localparam int LW   = RW + 1;
  localparam int CIW  = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
  localparam int CUW  = $clog2(SIZE_CLASSES + 1);
  localparam int OW   = $clog2(DATA_BYTES);
  localparam int BW   = $clog2(DATA_BYTES + 1);
  localparam int SW   = ((BW > 16) ? BW : 16) + 1;
  localparam int CMPW = (RUW > 8) ? RUW : 8;
  localparam int STW  = $clog2(MAX_RECORDS + 1);

  logic [2:0]     op_r;
  logic [15:0]    sz_r;
  logic [7:0]     id_r;
  logic [7:0]     prev_r;
  logic [RUW-1:0] records_used_r;
  logic [BW-1:0]  bytes_used_r;
  logic [CUW-1:0] classes_used_r;
  logic [15:0]    class_size_r [SIZE_CLASSES];
  logic [LW-1:0]  class_head_r [SIZE_CLASSES];
  logic           hit_r;
  logic [CIW-1:0] cidx_r;
  logic [RW-1:0]  cur_r;
  logic [LW-1:0]  follow_r;
  logic [STW-1:0] step_r;
  logic [2:0]     st_r;
  logic [RW-1:0]  rid_r;
  logic [OW-1:0]  off_r;
  logic [8:0]     nxt_r;
  logic [2:0]     out_status_r;
  logic [7:0]     out_result_id_r;
  logic [15:0]    out_data_offset_r;
  logic [8:0]     out_next_id_r;

  logic [15:0]    rd_size;
  logic [OW-1:0]  rd_off;
  logic [LW-1:0]  rd_link;
  logic [RW-1:0]  raddr;
  logic           size_we;
  logic           link_we;
  logic [RW-1:0]  link_waddr;
  logic [LW-1:0]  link_wdata;
  logic [RW-1:0]  new_id;
  logic [LW-1:0]  head;
  logic [SW-1:0]  sum_w;
  logic [15:0]    key;
  logic           hit_c;
  logic [CIW-1:0] idx_c;
  logic [8:0]     rd_link9;

  assign new_id   = RW'(records_used_r);
  assign head     = class_head_r[cidx_r];
  assign sum_w    = SW'(bytes_used_r) + SW'(sz_r);
  assign rd_link9 = rd_link[LW-1] ? 9'h1FF : 9'(rd_link[RW-1:0]);

  always_comb begin
    case (cmd.ra_sel)
      RA_ID:   raddr = RW'(id_r);
      RA_HEAD: raddr = head[RW-1:0];
      RA_CUR:  raddr = cur_r;
      default: raddr = RW'(id_r);
    endcase
  end

  always_comb begin
    link_we    = 1'b0;
    link_waddr = new_id;
    link_wdata = '1;
    if (cmd.do_fresh) begin
      link_we = 1'b1;
    end else if (cmd.do_reuse) begin
      link_we    = 1'b1;
      link_waddr = head[RW-1:0];
    end else if (cmd.do_link) begin
      link_we    = 1'b1;
      link_waddr = RW'(prev_r);
      link_wdata = {1'b0, rid_r};
    end else if (cmd.walk_upd && hit_r) begin
      link_we    = 1'b1;
      link_waddr = cur_r;
      link_wdata = head;
    end
  end

  assign size_we = cmd.do_fresh;

  scra_ram #(.W(16), .D(MAX_RECORDS)) u_size_ram (
    .clk, .we(size_we), .waddr(new_id), .wdata(sz_r), .raddr, .rdata(rd_size)
  );

  scra_ram #(.W(OW), .D(MAX_RECORDS)) u_off_ram (
    .clk, .we(size_we), .waddr(new_id), .wdata(OW'(bytes_used_r)), .raddr,
    .rdata(rd_off)
  );

  scra_ram #(.W(LW), .D(MAX_RECORDS)) u_link_ram (
    .clk, .we(link_we), .waddr(link_waddr), .wdata(link_wdata), .raddr,
    .rdata(rd_link)
  );

  always_comb begin
    key   = cmd.key_ram ? rd_size : sz_r;
    hit_c = 1'b0;
    idx_c = '0;
    for (int i = SIZE_CLASSES - 1; i >= 0; i--) begin
      if (CUW'(i) < classes_used_r && class_size_r[i] == key) begin
        hit_c = 1'b1;
        idx_c = CIW'(i);
      end
    end
  end

  always_comb begin
    stat.op         = op_r;
    stat.id_ok      = CMPW'(id_r) < CMPW'(records_used_r);
    stat.prev_ok    = CMPW'(prev_r) < CMPW'(records_used_r);
    stat.hit        = hit_r;
    stat.head_ok    = !head[LW-1] && (RUW'(head[RW-1:0]) < records_used_r);
    stat.class_full = classes_used_r >= CUW'(SIZE_CLASSES);
    stat.recs_full  = records_used_r >= RUW'(MAX_RECORDS);
    stat.data_full  = (bytes_used_r == BW'(DATA_BYTES)) || (sum_w > SW'(DATA_BYTES));
    stat.size_match = rd_size == sz_r;
    stat.follow_ok  = !follow_r[LW-1] && (RUW'(follow_r[RW-1:0]) < records_used_r);
    stat.step_last  = step_r == STW'(MAX_RECORDS - 1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      records_used_r <= '0;
      bytes_used_r   <= '0;
      classes_used_r <= '0;
    end else if (cmd.do_clear) begin
      records_used_r <= '0;
      bytes_used_r   <= '0;
      classes_used_r <= '0;
    end else if (cmd.do_fresh) begin
      records_used_r <= records_used_r + 1'b1;
      bytes_used_r   <= BW'(sum_w);
      if (!hit_r) begin
        classes_used_r <= classes_used_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r   <= in_operation;
      sz_r   <= in_record_size;
      id_r   <= in_record_id;
      prev_r <= in_prev_id;
      st_r   <= ST_OK;
      rid_r  <= '0;
      off_r  <= '0;
      nxt_r  <= '0;
    end
    if (cmd.lookup) begin
      hit_r  <= hit_c;
      cidx_r <= idx_c;
    end
    if (cmd.set_st) begin
      st_r <= cmd.st_code;
    end
    if (cmd.do_fresh) begin
      rid_r <= new_id;
      off_r <= OW'(bytes_used_r);
      nxt_r <= '1;
      if (!hit_r) begin
        class_size_r[CIW'(classes_used_r)] <= sz_r;
        class_head_r[CIW'(classes_used_r)] <= '1;
      end
    end
    if (cmd.do_reuse) begin
      class_head_r[cidx_r] <= rd_link;
      rid_r <= head[RW-1:0];
      off_r <= rd_off;
      nxt_r <= '1;
    end
    if (cmd.do_link) begin
      nxt_r <= 9'(rid_r);
    end
    if (cmd.do_read) begin
      off_r <= rd_off;
      nxt_r <= rd_link9;
    end
    if (cmd.walk_init) begin
      cur_r  <= RW'(id_r);
      step_r <= '0;
    end
    if (cmd.walk_cmp) begin
      follow_r <= rd_link;
    end
    if (cmd.walk_upd) begin
      if (hit_r) begin
        class_head_r[cidx_r] <= {1'b0, cur_r};
      end
      cur_r  <= follow_r[RW-1:0];
      step_r <= step_r + 1'b1;
    end
    if (cmd.load_out) begin
      out_status_r      <= st_r;
      out_result_id_r   <= 8'(rid_r);
      out_data_offset_r <= 16'(off_r);
      out_next_id_r     <= nxt_r;
    end
  end

  assign out_status      = out_status_r;
  assign out_result_id   = out_result_id_r;
  assign out_data_offset = out_data_offset_r;
  assign out_next_id     = out_next_id_r;

endmodule

[rtl/scra_ctrl.sv]
// Controller: sequences each operation and owns both handshakes.
module scra_ctrl import scra_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [9:0] {
    S_IDLE  = 10'b0000000001,
    S_LOOK  = 10'b0000000010,
    S_DISP  = 10'b0000000100,
    S_HEAD  = 10'b0000001000,
    S_REUSE = 10'b0000010000,
    S_LINK  = 10'b0000100000,
    S_WCMP  = 10'b0001000000,
    S_WUPD  = 10'b0010000000,
    S_WRD   = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.ra_sel    = RA_ID;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.lookup = 1'b1;
        state_nxt  = S_DISP;
      end
      S_DISP: begin
        state_nxt = S_FIN;
        case (stat.op)
          OP_ALLOC, OP_APPEND: begin
            if (stat.op == OP_APPEND && !stat.prev_ok) begin
              cmd.set_st  = 1'b1;
              cmd.st_code = ST_BAD_ID;
            end else if (!stat.hit && stat.class_full) begin
              cmd.set_st  = 1'b1;
              cmd.st_code = ST_CLASS_FULL;
            end else if (stat.hit && stat.head_ok) begin
              state_nxt = S_HEAD;
            end else if (stat.recs_full) begin
              cmd.set_st  = 1'b1;
              cmd.st_code = ST_RECS_FULL;
            end else if (stat.data_full) begin
              cmd.set_st  = 1'b1;
              cmd.st_code = ST_DATA_FULL;
            end else begin
              cmd.do_fresh = 1'b1;
              if (stat.op == OP_APPEND) begin
                state_nxt = S_LINK;
              end
            end
          end
          OP_READ: begin
            if (!stat.id_ok) begin
              cmd.set_st  = 1'b1;
              cmd.st_code = ST_BAD_ID;
            end else if (!stat.size_match) begin
              cmd.set_st  = 1'b1;
              cmd.st_code = ST_SIZE;
            end else begin
              cmd.do_read = 1'b1;
            end
          end
          OP_ERASE: begin
            if (!stat.id_ok) begin
              cmd.set_st  = 1'b1;
              cmd.st_code = ST_BAD_ID;
            end else begin
              cmd.walk_init = 1'b1;
              state_nxt     = S_WCMP;
            end
          end
          OP_CLEAR: begin
            cmd.do_clear = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_HEAD: begin
        cmd.ra_sel = RA_HEAD;
        state_nxt  = S_REUSE;
      end
      S_REUSE: begin
        cmd.do_reuse = 1'b1;
        state_nxt    = (stat.op == OP_APPEND) ? S_LINK : S_FIN;
      end
      S_LINK: begin
        cmd.do_link = 1'b1;
        state_nxt   = S_FIN;
      end
      S_WCMP: begin
        cmd.lookup   = 1'b1;
        cmd.key_ram  = 1'b1;
        cmd.walk_cmp = 1'b1;
        state_nxt    = S_WUPD;
      end
      S_WUPD: begin
        cmd.walk_upd = 1'b1;
        state_nxt    = (stat.follow_ok && !stat.step_last) ? S_WRD : S_FIN;
      end
      S_WRD: begin
        cmd.ra_sel = RA_CUR;
        state_nxt  = S_WCMP;
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[rtl/size_class_record_allocator_unit.sv]
// Top level of the size class record allocator.
//
//  channel | direction | handshake            | word
//  in_     | input     | in_valid / in_stall   | operation, record_size, record_id, prev_id
//  out_    | output    | out_valid / out_stall | status, result_id, data_offset, next_id
//
// Allocate from a fresh record, read, clear and failures pass load, lookup, dispatch
// and finish; reuse from a free list adds head read and reuse, append adds a link write.
// Erase walks records through compare and update, with a link table read between them.
// Reset is synchronous and needs no clearing pass; table entries are written before use.
// A stalled result holds in the output register; the next word is taken meanwhile.
module size_class_record_allocator_unit import scra_pkg::*; #(
  parameter int MAX_RECORDS  = 256,
  parameter int SIZE_CLASSES = 16,
  parameter int DATA_BYTES   = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [15:0] in_record_size,
  input  logic [7:0]  in_record_id,
  input  logic [7:0]  in_prev_id,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [7:0]  out_result_id,
  output logic [15:0] out_data_offset,
  output logic [8:0]  out_next_id
);

  cmd_t  cmd;
  stat_t stat;

  scra_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .stat, .cmd
  );

  scra_dp #(
    .MAX_RECORDS(MAX_RECORDS), .SIZE_CLASSES(SIZE_CLASSES), .DATA_BYTES(DATA_BYTES)
  ) u_dp (
    .clk, .rst_n, .cmd, .stat, .in_operation, .in_record_size, .in_record_id,
    .in_prev_id, .out_status, .out_result_id, .out_data_offset, .out_next_id
  );

endmodule

[rtl/scra_checker.sv]
// Port level checks for the size class record allocator, bound to the top level.
module scra_checker import scra_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  out_status,
  input logic [7:0]  out_result_id,
  input logic [15:0] out_data_offset,
  input logic [8:0]  out_next_id
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status) &&
    $stable(out_result_id) && $stable(out_data_offset) && $stable(out_next_id))
    else $error("stalled result word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while one is in work");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_CLASS_FULL)
    else $error("status code out of range");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |->
    out_result_id == 8'd0 && out_data_offset == 16'd0 && out_next_id == 9'd0)
    else $error("failed operation returned nonzero fields");

endmodule

bind size_class_record_allocator_unit scra_checker u_scra_checker (.*);
